// ----- hdl/pse_pkg.sv -----
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and constants for the postfix stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DIV_CNT_W   = $clog2(DATA_W + 1);

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_OVER    = 2'd2,
    ST_DIVZERO = 2'd3
  } status_e;

  typedef struct packed {
    logic load_up;
    logic load_down;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/postfix_stack_evaluator.sv -----
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Reverse Polish integer evaluator over a shifting stack of cells.
// ----------------------------------------------------------------------------
// One token word per input handshake. Push, add, subtract and multiply finish
// as the word is accepted; a divide stalls input while the radix-2 divider
// starts, iterates once per quotient bit and writes back. The stack is a row
// of STACK_DEPTH cells with the top in cell 0; pushes shift the row down and
// operators shift it up. A word with last set yields one result word holding
// the top of stack (zero if empty) and the first error of the expression,
// then clears the stack. The result sits in an output register, so tokens
// keep flowing while it waits, except a further last token.
`default_nettype none

module postfix_stack_evaluator
  import pse_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [2:0]        in_op_i,
  input  wire logic [DATA_W-1:0] in_operand_i,
  input  wire logic              in_last_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [DATA_W-1:0] out_value_o,
  output logic      [1:0]        out_status_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  status_e           err_q, err_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;
  status_e           out_status_q, out_status_d;

  logic [DATA_W-1:0] cell_data [STACK_DEPTH];
  logic [DATA_W-1:0] cell_up   [STACK_DEPTH];
  logic [DATA_W-1:0] cell_down [STACK_DEPTH];
  cell_ctrl_t        cell_ctrl [STACK_DEPTH];

  logic              accept;
  logic              push;
  logic              pop_write;
  logic [DATA_W-1:0] top_din;
  logic [DATA_W-1:0] rhs, lhs;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] top_new;
  logic [CNT_W-1:0]  cnt_new;
  status_e           err_new;
  logic              emit;
  logic              div_start;
  logic              div_busy;
  logic [DATA_W-1:0] div_quot;

  assign rhs = cell_data[0];
  assign lhs = cell_data[1];

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i && in_last_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    case (op_e'(in_op_i))
      OP_ADD:  alu_res = lhs + rhs;
      OP_SUB:  alu_res = lhs - rhs;
      OP_MUL:  alu_res = lhs * rhs;
      default: alu_res = '0;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    err_d        = err_q;
    last_d       = last_q;
    push         = 1'b0;
    pop_write    = 1'b0;
    top_din      = in_operand_i;
    div_start    = 1'b0;
    emit         = 1'b0;
    top_new      = (count_q != '0) ? rhs : '0;
    cnt_new      = count_q;
    err_new      = err_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_e'(in_op_i)) inside
            OP_PUSH: begin
              if (count_q == CNT_W'(STACK_DEPTH)) begin
                if (err_q == ST_OK) err_new = ST_OVER;
              end else begin
                push    = 1'b1;
                top_new = in_operand_i;
                cnt_new = count_q + 1'b1;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (count_q < CNT_W'(2)) begin
                if (err_q == ST_OK) err_new = ST_UNDER;
              end else if (op_e'(in_op_i) == OP_DIV) begin
                if (rhs == '0) begin
                  if (err_q == ST_OK) err_new = ST_DIVZERO;
                end else begin
                  div_start = 1'b1;
                end
              end else begin
                pop_write = 1'b1;
                top_din   = alu_res;
                top_new   = alu_res;
                cnt_new   = count_q - 1'b1;
              end
            end
            default: ;
          endcase

          if (div_start) begin
            state_d = S_DIV;
            last_d  = in_last_i;
          end else if (in_last_i) begin
            emit         = 1'b1;
            out_value_d  = top_new;
            out_status_d = err_new;
            count_d      = '0;
            err_d        = ST_OK;
          end else begin
            count_d = cnt_new;
            err_d   = err_new;
          end
        end
      end
      S_DIV: begin
        if (!div_busy && !(last_q && out_valid_q && out_stall_i)) begin
          pop_write = 1'b1;
          top_din   = div_quot;
          state_d   = S_IDLE;
          if (last_q) begin
            emit         = 1'b1;
            out_value_d  = div_quot;
            out_status_d = err_q;
            count_d      = '0;
            err_d        = ST_OK;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // cell 0 is the top of stack
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (i == 0) begin
        cell_up[i]   = top_din;
        cell_down[i] = '0;
        cell_ctrl[i] = '{load_up: push || pop_write, load_down: 1'b0};
      end else begin
        cell_up[i]   = cell_data[i-1];
        cell_down[i] = (i == STACK_DEPTH - 1) ? '0 : cell_data[(i+1) % STACK_DEPTH];
        cell_ctrl[i] = '{load_up: push, load_down: pop_write};
      end
    end
  end

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    pse_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[g]),
      .up_i   (cell_up[g]),
      .down_i (cell_down[g]),
      .data_o (cell_data[g])
    );
  end

  pse_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (lhs),
    .den_i   (rhs),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= ST_OK;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_div_holds_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == S_DIV) && in_stall_o)
    else $error("divider running outside divide state");

  a_emit_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (count_q == '0) && (err_q == ST_OK) && out_valid_q)
    else $error("stack not cleared after result");

  a_emit_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !(out_valid_q && out_stall_i))
    else $error("result overwrote a pending word");

endmodule

`default_nettype wire

// ----- hdl/pse_cell.sv -----
// ----------------------------------------------------------------------------
// pse_cell
// One stack entry: takes the word above on a push, the word below on a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_cell
  import pse_pkg::*;
(
  input  wire logic              clk_i,
  input  wire cell_ctrl_t        ctrl_i,
  input  wire logic [DATA_W-1:0] up_i,
  input  wire logic [DATA_W-1:0] down_i,
  output logic      [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load_up) begin
      data_d = up_i;
    end else if (ctrl_i.load_down) begin
      data_d = down_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- hdl/pse_div.sv -----
// ----------------------------------------------------------------------------
// pse_div
// Radix-2 restoring signed divider, truncating, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_div
  import pse_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DATA_W-1:0] num_i,
  input  wire logic [DATA_W-1:0] den_i,
  output logic                   busy_o,
  output logic      [DATA_W-1:0] quot_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]    quo_q, quo_d;
  logic [DATA_W-1:0]    den_q, den_d;
  logic                 neg_q, neg_d;
  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      diff;

  always_comb begin
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    neg_d   = neg_q;
    shifted = {rem_q, quo_q[DATA_W-1]};
    diff    = shifted - {1'b0, den_q};
    if (start_i) begin
      cnt_d = DIV_CNT_W'(DATA_W);
      rem_d = '0;
      quo_d = num_i[DATA_W-1] ? (~num_i + 1'b1) : num_i;
      den_d = den_i[DATA_W-1] ? (~den_i + 1'b1) : den_i;
      neg_d = num_i[DATA_W-1] ^ den_i[DATA_W-1];
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
      quo_d = {quo_q[DATA_W-2:0], ~diff[DATA_W]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

`default_nettype wire

// ----- sim/rpn_eval_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_eval_checker
// Watches both channels of the postfix evaluator, predicts each expression
// result from the accepted tokens and compares it field by field.
// ----------------------------------------------------------------------------
module rpn_eval_checker
  import pse_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_stall_i,
  input  wire logic [2:0]        in_op_i,
  input  wire logic [DATA_W-1:0] in_operand_i,
  input  wire logic              in_last_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_stall_i,
  input  wire logic [DATA_W-1:0] out_value_i,
  input  wire logic [1:0]        out_status_i,
  output int unsigned            pending_o,
  output int unsigned            results_o,
  output int unsigned            errors_o
);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_e           status;
  } expr_result_t;

  logic [DATA_W-1:0] eval_stack [STACK_DEPTH];
  int unsigned       eval_depth;
  status_e           eval_error;
  expr_result_t      awaited_results [$];
  expr_result_t      oldest;

  function automatic void note_error(input status_e code);
    if (eval_error == ST_OK) eval_error = code;
  endfunction

  function automatic void evaluate_token(input logic [2:0] op,
                                         input logic [DATA_W-1:0] operand,
                                         input logic lst);
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] res;
    longint            quotient;
    logic              applied;
    expr_result_t      outcome;
    applied = 1'b1;
    res = '0;
    case (op)
      OP_PUSH: begin
        if (eval_depth >= STACK_DEPTH) begin
          note_error(ST_OVER);
        end else begin
          eval_stack[eval_depth] = operand;
          eval_depth++;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (eval_depth < 2) begin
          note_error(ST_UNDER);
        end else begin
          rhs = eval_stack[eval_depth-1];
          lhs = eval_stack[eval_depth-2];
          case (op)
            OP_ADD: res = lhs + rhs;
            OP_SUB: res = lhs - rhs;
            OP_MUL: res = lhs * rhs;
            default: begin
              if (rhs == '0) begin
                note_error(ST_DIVZERO);
                applied = 1'b0;
              end else begin
                // 64-bit so that most negative over minus one wraps cleanly
                quotient = longint'($signed(lhs)) / longint'($signed(rhs));
                res = quotient[DATA_W-1:0];
              end
            end
          endcase
          if (applied) begin
            eval_stack[eval_depth-2] = res;
            eval_depth--;
          end
        end
      end
      default: ;
    endcase
    if (lst) begin
      outcome.value  = (eval_depth > 0) ? eval_stack[eval_depth-1] : '0;
      outcome.status = eval_error;
      awaited_results.push_back(outcome);
      eval_depth = 0;
      eval_error = ST_OK;
    end
  endfunction

  // Sampled mid-cycle: the values held here decide the next rising edge.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_depth = 0;
      eval_error = ST_OK;
      awaited_results.delete();
      pending_o = 0;
      results_o = 0;
      errors_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (awaited_results.size() == 0) begin
          $display("%0t: result word with none expected: value %h status %0d",
                   $time, out_value_i, out_status_i);
          errors_o++;
        end else begin
          oldest = awaited_results.pop_front();
          if (out_value_i !== oldest.value) begin
            $display("%0t: value mismatch: expected %h, actual %h",
                     $time, oldest.value, out_value_i);
            errors_o++;
          end
          if (out_status_i !== oldest.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, oldest.status, out_status_i);
            errors_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) evaluate_token(in_op_i, in_operand_i, in_last_i);
      pending_o = awaited_results.size();
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the postfix stack evaluator.
// ----------------------------------------------------------------------------
// Directed expressions hit wrap-around, the most negative quotient, divide by
// zero, underflow, overflow, sticky errors and the spare op codes; then random
// well-formed expressions mixed with noise run under three idling patterns.
module tb_top;
  import pse_pkg::*;

  localparam int unsigned RANDOM_TOKENS = 500;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam longint      RUN_LIMIT_NS  = 64'd5_000_000;

  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [2:0]        in_op      = '0;
  logic [DATA_W-1:0] in_operand = '0;
  logic              in_last    = 1'b0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [DATA_W-1:0] out_value;
  logic [1:0]        out_status;

  int unsigned pending;
  int unsigned results;
  int unsigned errors;
  int unsigned tokens_sent = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  always #6 clk = ~clk;

  postfix_stack_evaluator u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_op_i      (in_op),
    .in_operand_i (in_operand),
    .in_last_i    (in_last),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_value_o  (out_value),
    .out_status_o (out_status)
  );

  rpn_eval_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_op_i      (in_op),
    .in_operand_i (in_operand),
    .in_last_i    (in_last),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_value_i  (out_value),
    .out_status_i (out_status),
    .pending_o    (pending),
    .results_o    (results),
    .errors_o     (errors)
  );

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < rx_idle_pct);
  end

  function automatic logic [DATA_W-1:0] random_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      4, 5, 6: return $urandom_range(0, 40) - 20;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_token(input logic [2:0] op, input logic [DATA_W-1:0] operand,
                            input logic lst);
    logic taken;
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_operand <= operand;
    in_last    <= lst;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (op <= OP_DIV || lst) tokens_sent++;
  endtask

  task automatic send_expression(input int unsigned operands);
    int unsigned depth;
    int unsigned pushed;
    logic [2:0]  op;
    depth  = 0;
    pushed = 0;
    while (pushed < operands || depth > 1) begin
      if (depth < 2 || (pushed < operands && $urandom_range(0, 1) == 1)) begin
        op = OP_PUSH;
        pushed++;
        depth++;
      end else begin
        op = 3'($urandom_range(int'(OP_ADD), int'(OP_DIV)));
        depth--;
      end
      send_token(op, random_operand(), pushed == operands && depth == 1);
    end
  endtask

  task automatic send_noise();
    int unsigned count;
    count = $urandom_range(1, 8);
    repeat (count) begin
      send_token(3'($urandom_range(int'(OP_PUSH), int'(OP_SPARE_C))), $urandom(),
                 $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    #(RUN_LIMIT_NS);
    $display("postfix_stack_evaluator verification failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 35;
    rx_idle_pct = 48;

    // empty stack at end, through a spare code
    send_token(OP_SPARE_A, '0, 1'b1);
    // add wraps past the largest positive value
    send_token(OP_PUSH, 32'h7fff_ffff, 1'b0);
    send_token(OP_PUSH, 32'h0000_0001, 1'b0);
    send_token(OP_ADD, '0, 1'b1);
    // most negative over minus one
    send_token(OP_PUSH, 32'h8000_0000, 1'b0);
    send_token(OP_PUSH, 32'hffff_ffff, 1'b0);
    send_token(OP_DIV, '0, 1'b1);
    // divide by zero stays sticky while evaluation goes on
    send_token(OP_PUSH, 32'h0000_0001, 1'b0);
    send_token(OP_PUSH, '0, 1'b0);
    send_token(OP_DIV, '1, 1'b0);
    send_token(OP_SPARE_B, '1, 1'b0);
    send_token(OP_ADD, '0, 1'b1);
    // subtract with a single entry underflows
    send_token(OP_PUSH, 32'h8000_0000, 1'b0);
    send_token(OP_SPARE_C, '0, 1'b0);
    send_token(OP_SUB, '0, 1'b1);
    // one push too many, then multiply the top two
    for (int i = 0; i <= STACK_DEPTH; i++) send_token(OP_PUSH, random_operand(), 1'b0);
    send_token(OP_MUL, '0, 1'b1);
    wait_for_results();

    tokens_sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 35; rx_idle_pct = 48; end
        1: begin tx_idle_pct = 48; rx_idle_pct = 35; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      while (tokens_sent < (phase + 1) * RANDOM_TOKENS / 3) begin
        if ($urandom_range(0, 4) == 0) begin
          send_noise();
        end else if ($urandom_range(0, 7) == 0) begin
          send_expression($urandom_range(7, STACK_DEPTH + 2));
        end else begin
          send_expression($urandom_range(1, 6));
        end
      end
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d random tokens after the directed cases; checked %0d results.",
             tokens_sent, results);
    $display("Idling ran receiver-heavy, then sender-heavy, then not at all.");
    if (errors == 0 && pending == 0) begin
      $display("postfix_stack_evaluator verification clean");
    end else begin
      $display("postfix_stack_evaluator verification failed");
    end
    $finish;
  end

endmodule
